// ===== hdl/linked_list_position_engine_unit_assert.svh =====
// Assertion macros used by the list engine RTL.
`ifndef LINKED_LIST_POSITION_ENGINE_UNIT_ASSERT_SVH
`define LINKED_LIST_POSITION_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LLPE_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("list engine invariant violated");
`define LLPE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list engine implication violated");
`else
`define LLPE_ASSERT_ALWAYS(label, clk, rst, expr)
`define LLPE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/llpe_pkg.sv =====
package llpe_pkg;

   localparam int CAPACITY   = 256;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int VAL_W      = 8;
   localparam int ACT_W      = 3;
   localparam int POS_W      = 9;
   localparam int STAT_W     = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;
   localparam int NODE_W     = CNT_W + VAL_W;

   localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(CAPACITY);

   localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_READ   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_LOCATE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_POS  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [CNT_W-1:0] link;
      logic [VAL_W-1:0] value;
   } node_type;

endpackage

// ===== hdl/llpe_ram.sv =====
module llpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/linked_list_position_engine_unit.sv =====
// Singly linked list of bytes in a pool of 256 nodes. Each request transfer carries an action
// (insert, delete, read, locate, clear) and gives exactly one response transfer with a status,
// the byte read or removed, the found position, the new length and an empty flag. Requests
// are taken one at a time. An item walks the links from the head through the node memory,
// one node per cycle on its single read port. Clear, rejected requests and operations at the head
// walk no links. The longest item is an insert at the tail of a list that is one node short of
// full. Freed nodes go on a free stack in a second memory, so no clearing pass is needed after
// reset or clear.
`include "linked_list_position_engine_unit_assert.svh"

module linked_list_position_engine_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // position [8:0], value [16:9]
   input  logic [llpe_pkg::REQ_DATA_W-1:0] req_tdata,
   // action [2:0]
   input  logic [llpe_pkg::ACT_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_value [7:0], found_position [16:8], length [25:17], empty_res [26]
   output logic [llpe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status [1:0]
   output logic [llpe_pkg::STAT_W-1:0]     rsp_tuser
);

   import llpe_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_ALLOC    = 3'd2;
   localparam logic [2:0] S_WALK     = 3'd3;
   localparam logic [2:0] S_LINK     = 3'd4;
   localparam logic [2:0] S_HEAD_DEL = 3'd5;
   localparam logic [2:0] S_UNLINK   = 3'd6;
   localparam logic [2:0] S_RESP     = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [ACT_W-1:0]      act_ff, act_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [VAL_W-1:0]      key_ff, key_in;
   logic [CNT_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      hwm_ff, hwm_in;
   logic [CNT_W-1:0]      fcnt_ff, fcnt_in;
   logic [CNT_W-1:0]      cur_ff, cur_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic [CNT_W-1:0]      tgt_ff, tgt_in;
   logic [IDX_W-1:0]      fr_ff, fr_in;
   logic                  pop_ff, pop_in;
   node_type              prev_ff, prev_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic [VAL_W-1:0]      rdv_ff, rdv_in;
   logic [POS_W-1:0]      found_ff, found_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]     rsp_user_ff, rsp_user_in;

   logic                  node_we, node_re;
   logic [IDX_W-1:0]      node_waddr, node_raddr;
   node_type              node_wdata, node_rd;
   logic [NODE_W-1:0]     node_rdata;
   logic                  stk_we, stk_re;
   logic [IDX_W-1:0]      stk_waddr, stk_raddr, stk_wdata, stk_rdata;
   logic [IDX_W-1:0]      fr_sel;
   logic                  walk_start, walk_next;

   llpe_ram #(.WIDTH(NODE_W), .DEPTH(CAPACITY)) u_node_ram (
      .clock (clock),
      .we    (node_we),
      .waddr (node_waddr),
      .wdata (node_wdata),
      .re    (node_re),
      .raddr (node_raddr),
      .rdata (node_rdata)
   );

   llpe_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .re    (stk_re),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   assign node_rd    = node_type'(node_rdata);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign fr_sel     = pop_ff ? stk_rdata : fr_ff;

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      hwm_in       = hwm_ff;
      fcnt_in      = fcnt_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      tgt_in       = tgt_ff;
      fr_in        = fr_ff;
      pop_in       = pop_ff;
      prev_in      = prev_ff;
      status_in    = status_ff;
      rdv_in       = rdv_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      node_we      = 1'b0;
      node_waddr   = '0;
      node_wdata   = '0;
      node_re      = 1'b0;
      node_raddr   = '0;
      stk_we       = 1'b0;
      stk_waddr    = '0;
      stk_wdata    = '0;
      stk_re       = 1'b0;
      stk_raddr    = '0;
      walk_start   = 1'b0;
      walk_next    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               act_in    = req_tuser;
               pos_in    = req_tdata[POS_W-1:0];
               key_in    = req_tdata[POS_W+VAL_W-1:POS_W];
               status_in = STAT_OK;
               rdv_in    = '0;
               found_in  = '0;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            unique case (act_ff)
               ACT_INSERT: begin
                  if (pos_ff == '0 || (pos_ff > count_ff && pos_ff != count_ff + 1'b1)) begin
                     status_in = STAT_BAD_POS;
                  end else if (count_ff == CNT_W'(CAPACITY)) begin
                     status_in = STAT_FULL;
                  end else begin
                     if (fcnt_ff != '0) begin
                        stk_re    = 1'b1;
                        stk_raddr = IDX_W'(fcnt_ff - 1'b1);
                        fcnt_in   = fcnt_ff - 1'b1;
                        pop_in    = 1'b1;
                     end else begin
                        fr_in  = hwm_ff[IDX_W-1:0];
                        hwm_in = hwm_ff + 1'b1;
                        pop_in = 1'b0;
                     end
                     state_in = S_ALLOC;
                  end
               end
               ACT_DELETE: begin
                  if (pos_ff == '0 || pos_ff > count_ff) begin
                     status_in = STAT_BAD_POS;
                  end else if (pos_ff == POS_W'(1)) begin
                     node_re    = 1'b1;
                     node_raddr = head_ff[IDX_W-1:0];
                     state_in   = S_HEAD_DEL;
                  end else begin
                     walk_start = 1'b1;
                     tgt_in     = pos_ff - 1'b1;
                  end
               end
               ACT_READ: begin
                  if (pos_ff == '0 || pos_ff > count_ff) begin
                     status_in = STAT_BAD_POS;
                  end else begin
                     walk_start = 1'b1;
                     tgt_in     = pos_ff;
                  end
               end
               ACT_LOCATE: begin
                  if (count_ff == '0) begin
                     status_in = STAT_NOTFOUND;
                  end else begin
                     walk_start = 1'b1;
                     tgt_in     = count_ff;
                  end
               end
               ACT_CLEAR: begin
                  head_in  = NULL_LINK;
                  count_in = '0;
                  hwm_in   = '0;
                  fcnt_in  = '0;
               end
               default: begin
               end
            endcase
         end
         S_ALLOC: begin
            fr_in = fr_sel;
            if (pos_ff == POS_W'(1)) begin
               node_we    = 1'b1;
               node_waddr = fr_sel;
               node_wdata = '{link: head_ff, value: key_ff};
               head_in    = CNT_W'(fr_sel);
               count_in   = count_ff + 1'b1;
               state_in   = S_RESP;
            end else begin
               walk_start = 1'b1;
               tgt_in     = pos_ff - 1'b1;
            end
         end
         S_WALK: begin
            priority if (act_ff == ACT_LOCATE && node_rd.value == key_ff) begin
               found_in = k_ff;
               state_in = S_RESP;
            end else if (k_ff != tgt_ff) begin
               walk_next = 1'b1;
            end else begin
               state_in = S_RESP;
               unique case (act_ff)
                  ACT_INSERT: begin
                     node_we    = 1'b1;
                     node_waddr = fr_ff;
                     node_wdata = '{link: node_rd.link, value: key_ff};
                     prev_in    = node_rd;
                     state_in   = S_LINK;
                  end
                  ACT_DELETE: begin
                     prev_in    = node_rd;
                     node_re    = 1'b1;
                     node_raddr = node_rd.link[IDX_W-1:0];
                     state_in   = S_UNLINK;
                  end
                  ACT_READ: begin
                     rdv_in = node_rd.value;
                  end
                  ACT_LOCATE: begin
                     status_in = STAT_NOTFOUND;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LINK: begin
            node_we    = 1'b1;
            node_waddr = cur_ff[IDX_W-1:0];
            node_wdata = '{link: CNT_W'(fr_ff), value: prev_ff.value};
            count_in   = count_ff + 1'b1;
            state_in   = S_RESP;
         end
         S_HEAD_DEL: begin
            head_in   = node_rd.link;
            stk_we    = 1'b1;
            stk_waddr = fcnt_ff[IDX_W-1:0];
            stk_wdata = head_ff[IDX_W-1:0];
            fcnt_in   = fcnt_ff + 1'b1;
            rdv_in    = node_rd.value;
            count_in  = count_ff - 1'b1;
            state_in  = S_RESP;
         end
         S_UNLINK: begin
            node_we    = 1'b1;
            node_waddr = cur_ff[IDX_W-1:0];
            node_wdata = '{link: node_rd.link, value: prev_ff.value};
            stk_we     = 1'b1;
            stk_waddr  = fcnt_ff[IDX_W-1:0];
            stk_wdata  = prev_ff.link[IDX_W-1:0];
            fcnt_in    = fcnt_ff + 1'b1;
            rdv_in     = node_rd.value;
            count_in   = count_ff - 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {5'b0, (count_ff == '0), count_ff, found_ff, rdv_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (walk_start) begin
         node_re    = 1'b1;
         node_raddr = head_ff[IDX_W-1:0];
         cur_in     = head_ff;
         k_in       = CNT_W'(1);
         state_in   = S_WALK;
      end
      if (walk_next) begin
         node_re    = 1'b1;
         node_raddr = node_rd.link[IDX_W-1:0];
         cur_in     = node_rd.link;
         k_in       = k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NULL_LINK;
         count_ff     <= '0;
         hwm_ff       <= '0;
         fcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         hwm_ff       <= hwm_in;
         fcnt_ff      <= fcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      pos_ff      <= pos_in;
      key_ff      <= key_in;
      cur_ff      <= cur_in;
      k_ff        <= k_in;
      tgt_ff      <= tgt_in;
      fr_ff       <= fr_in;
      pop_ff      <= pop_in;
      prev_ff     <= prev_in;
      status_ff   <= status_in;
      rdv_ff      <= rdv_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Between requests every allocated node is either on the list or back on the free stack.
   `LLPE_ASSERT_IMPLY(a_pool_balance, clock, reset, state_ff == S_IDLE, count_ff == hwm_ff - fcnt_ff)
   `LLPE_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `LLPE_ASSERT_IMPLY(a_empty_head, clock, reset, count_ff == '0, head_ff == NULL_LINK)

endmodule

// ===== bench/tb_linked_list_position_engine_unit.sv =====
`timescale 1ns / 1ps

module tb_linked_list_position_engine_unit;
   import llpe_pkg::*;

   localparam logic [ACT_W-1:0] ACT_SPARE_5 = 3'd5;
   localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
   localparam int POOL_NODES    = CAPACITY;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 1125;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [VAL_W-1:0]  read_value;
      logic [POS_W-1:0]  found_position;
      logic [POS_W-1:0]  length;
      logic              empty_res;
   } list_result_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
      logic             fixed_result;
      list_result_type  result;
   } directed_row_type;

   localparam list_result_type NO_RESULT = '0;

   // Rows whose result is given here are checked against it; the others use the predictor.
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{ACT_READ,    9'd1,   8'h00, 1'b1, '{STAT_BAD_POS,  8'h00, 9'd0, 9'd0, 1'b1}},
      '{ACT_DELETE,  9'd0,   8'h00, 1'b1, '{STAT_BAD_POS,  8'h00, 9'd0, 9'd0, 1'b1}},
      '{ACT_INSERT,  9'd0,   8'h11, 1'b1, '{STAT_BAD_POS,  8'h00, 9'd0, 9'd0, 1'b1}},
      '{ACT_INSERT,  9'd2,   8'h11, 1'b1, '{STAT_BAD_POS,  8'h00, 9'd0, 9'd0, 1'b1}},
      '{ACT_LOCATE,  9'd0,   8'h00, 1'b1, '{STAT_NOTFOUND, 8'h00, 9'd0, 9'd0, 1'b1}},
      '{ACT_INSERT,  9'd1,   8'hFF, 1'b1, '{STAT_OK,       8'h00, 9'd0, 9'd1, 1'b0}},
      '{ACT_INSERT,  9'd2,   8'h00, 1'b0, NO_RESULT},
      '{ACT_INSERT,  9'd1,   8'h5A, 1'b0, NO_RESULT},
      '{ACT_INSERT,  9'd4,   8'hA5, 1'b0, NO_RESULT},
      '{ACT_INSERT,  9'd6,   8'h42, 1'b1, '{STAT_BAD_POS,  8'h00, 9'd0, 9'd4, 1'b0}},
      '{ACT_INSERT,  9'd511, 8'h42, 1'b1, '{STAT_BAD_POS,  8'h00, 9'd0, 9'd4, 1'b0}},
      '{ACT_READ,    9'd1,   8'h00, 1'b0, NO_RESULT},
      '{ACT_READ,    9'd4,   8'h00, 1'b0, NO_RESULT},
      '{ACT_READ,    9'd5,   8'h00, 1'b1, '{STAT_BAD_POS,  8'h00, 9'd0, 9'd4, 1'b0}},
      '{ACT_READ,    9'd511, 8'hFF, 1'b1, '{STAT_BAD_POS,  8'h00, 9'd0, 9'd4, 1'b0}},
      '{ACT_LOCATE,  9'd0,   8'h00, 1'b0, NO_RESULT},
      '{ACT_LOCATE,  9'd0,   8'h77, 1'b1, '{STAT_NOTFOUND, 8'h00, 9'd0, 9'd4, 1'b0}},
      '{ACT_SPARE_5, 9'd3,   8'hFF, 1'b1, '{STAT_OK,       8'h00, 9'd0, 9'd4, 1'b0}},
      '{ACT_SPARE_6, 9'd0,   8'h00, 1'b1, '{STAT_OK,       8'h00, 9'd0, 9'd4, 1'b0}},
      '{ACT_SPARE_7, 9'd511, 8'hFF, 1'b1, '{STAT_OK,       8'h00, 9'd0, 9'd4, 1'b0}},
      '{ACT_DELETE,  9'd4,   8'h00, 1'b0, NO_RESULT},
      '{ACT_DELETE,  9'd2,   8'h00, 1'b0, NO_RESULT},
      '{ACT_READ,    9'd0,   8'h00, 1'b1, '{STAT_BAD_POS,  8'h00, 9'd0, 9'd2, 1'b0}},
      '{ACT_CLEAR,   9'd0,   8'h00, 1'b1, '{STAT_OK,       8'h00, 9'd0, 9'd0, 1'b1}},
      '{ACT_INSERT,  9'd256, 8'hAA, 1'b1, '{STAT_BAD_POS,  8'h00, 9'd0, 9'd0, 1'b1}}
   };

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [ACT_W-1:0]      req_tuser  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;

   logic [VAL_W-1:0] list_bytes[$];
   list_result_type  pending_responses[$];
   bit               idle_on = 1'b1;
   int               failures = 0;
   int               counted_items = 0;
   int               peak_length = 0;
   int               sent_count[8];
   int               status_count[4];

   linked_list_position_engine_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Run timed out with %0d responses outstanding.", pending_responses.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic list_result_type apply_list_request(input logic [ACT_W-1:0] action,
         input logic [POS_W-1:0] position, input logic [VAL_W-1:0] value);
      list_result_type res;
      int count;
      int index;
      res   = '0;
      count = list_bytes.size();
      index = int'(position) - 1;
      case (action)
         ACT_INSERT: begin
            if (position == 0 || int'(position) > count + 1) res.status = STAT_BAD_POS;
            else if (count >= POOL_NODES) res.status = STAT_FULL;
            else list_bytes.insert(index, value);
         end
         ACT_DELETE: begin
            if (position == 0 || int'(position) > count) begin
               res.status = STAT_BAD_POS;
            end else begin
               res.read_value = list_bytes[index];
               list_bytes.delete(index);
            end
         end
         ACT_READ: begin
            if (position == 0 || int'(position) > count) res.status = STAT_BAD_POS;
            else res.read_value = list_bytes[index];
         end
         ACT_LOCATE: begin
            res.status = STAT_NOTFOUND;
            for (int k = 0; k < count; k++) begin
               if (list_bytes[k] == value) begin
                  res.status         = STAT_OK;
                  res.found_position = POS_W'(k + 1);
                  break;
               end
            end
         end
         ACT_CLEAR: list_bytes.delete();
         default: ;
      endcase
      res.length    = POS_W'(list_bytes.size());
      res.empty_res = (list_bytes.size() == 0);
      return res;
   endfunction

   task automatic send_request(input logic [ACT_W-1:0] action, input logic [POS_W-1:0] position,
         input logic [VAL_W-1:0] value, input bit use_known, input list_result_type known_result);
      list_result_type predicted;
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({value, position});
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);
      predicted = apply_list_request(action, position, value);
      pending_responses.push_back(use_known ? known_result : predicted);
      sent_count[action]++;
      status_count[predicted.status]++;
      counted_items++;
      if (int'(predicted.length) > peak_length) peak_length = int'(predicted.length);
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic random_request();
      int pick;
      int count;
      logic [ACT_W-1:0] action;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
      count    = list_bytes.size();
      pick     = $urandom_range(99);
      value    = VAL_W'($urandom);
      position = POS_W'($urandom_range(511));
      if (pick < 42) begin
         action = ACT_INSERT;
         if ($urandom_range(9) != 0) position = POS_W'($urandom_range(count + 1, 1));
      end else if (pick < 62) begin
         action = ACT_DELETE;
         if (count != 0 && $urandom_range(9) != 0) position = POS_W'($urandom_range(count, 1));
      end else if (pick < 78) begin
         action = ACT_READ;
         if (count != 0 && $urandom_range(9) != 0) position = POS_W'($urandom_range(count, 1));
      end else if (pick < 92) begin
         action = ACT_LOCATE;
         if (count != 0 && $urandom_range(3) != 0) value = list_bytes[$urandom_range(count - 1)];
      end else if (pick < 94) begin
         action = ACT_CLEAR;
      end else begin
         action = ACT_W'($urandom_range(7, 5));
      end
      send_request(action, position, value, 1'b0, NO_RESULT);
   endtask

   // Fills every node of the pool, probes the list at both ends and in the middle, and clears it again.
   task automatic fill_pool();
      while (list_bytes.size() < POOL_NODES)
         send_request(ACT_INSERT, POS_W'($urandom_range(list_bytes.size() + 1, 1)),
                      VAL_W'($urandom), 1'b0, NO_RESULT);
      send_request(ACT_INSERT, 9'd1, 8'h00, 1'b0, NO_RESULT);
      send_request(ACT_INSERT, 9'd257, 8'hFF, 1'b0, NO_RESULT);
      send_request(ACT_INSERT, 9'd258, 8'h0F, 1'b0, NO_RESULT);
      send_request(ACT_READ, 9'd256, 8'h00, 1'b0, NO_RESULT);
      send_request(ACT_READ, 9'd257, 8'h00, 1'b0, NO_RESULT);
      send_request(ACT_LOCATE, 9'd0, list_bytes[POOL_NODES - 1], 1'b0, NO_RESULT);
      send_request(ACT_LOCATE, 9'd0, VAL_W'($urandom), 1'b0, NO_RESULT);
      send_request(ACT_DELETE, 9'd257, 8'h00, 1'b0, NO_RESULT);
      send_request(ACT_DELETE, 9'd256, 8'h00, 1'b0, NO_RESULT);
      send_request(ACT_INSERT, 9'd256, 8'hC3, 1'b0, NO_RESULT);
      send_request(ACT_DELETE, 9'd128, 8'h00, 1'b0, NO_RESULT);
      send_request(ACT_INSERT, 9'd1, 8'h81, 1'b0, NO_RESULT);
      send_request(ACT_INSERT, POS_W'($urandom_range(257, 1)), 8'h7E, 1'b0, NO_RESULT);
      drain_responses();
      send_request(ACT_CLEAR, 9'd0, 8'h00, 1'b0, NO_RESULT);
   endtask

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !idle_on || ($urandom_range(99) >= 11);
   end

   always @(posedge clock) begin
      list_result_type got;
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[7:0], rsp_tdata[16:8], rsp_tdata[25:17], rsp_tdata[26]};
         if (pending_responses.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("Unexpected response transfer: status %0d read %02h found %0d length %0d",
                        got.status, got.read_value, got.found_position, got.length);
         end else begin
            want = pending_responses.pop_front();
            if (got.status !== want.status || got.read_value !== want.read_value ||
                got.found_position !== want.found_position || got.length !== want.length ||
                got.empty_res !== want.empty_res) begin
               failures++;
               if (failures <= 10) begin
                  $write("Response mismatch: expected status %0d read %02h found %0d ",
                         want.status, want.read_value, want.found_position);
                  $write("length %0d empty %0d, got status %0d read %02h ",
                         want.length, want.empty_res, got.status, got.read_value);
                  $display("found %0d length %0d empty %0d",
                           got.found_position, got.length, got.empty_res);
               end
            end
         end
      end
   end

   initial begin
      int episode;
      int burst;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_request(DIRECTED[r].action, DIRECTED[r].position, DIRECTED[r].value,
                      DIRECTED[r].fixed_result, DIRECTED[r].result);
      // The sender holds off here until every response transfer has arrived.
      drain_responses();

      episode = 0;
      while (counted_items < DIRECTED_ROWS + RANDOM_ITEMS) begin
         idle_on = (episode % 6) != 4;
         burst   = idle_on ? int'($urandom_range(120, 40)) : 160;
         if (burst > DIRECTED_ROWS + RANDOM_ITEMS - counted_items)
            burst = DIRECTED_ROWS + RANDOM_ITEMS - counted_items;
         if (episode == 2) fill_pool();
         else repeat (burst) random_request();
         if ($urandom_range(3) == 0) drain_responses();
         episode++;
      end
      drain_responses();
      idle_on = 1'b1;
      repeat (300) @(posedge clock);

      failures += pending_responses.size();
      $display("Sent %0d inserts, %0d deletes, %0d reads, %0d locates, %0d clears, %0d unused.",
               sent_count[ACT_INSERT], sent_count[ACT_DELETE], sent_count[ACT_READ],
               sent_count[ACT_LOCATE], sent_count[ACT_CLEAR],
               sent_count[ACT_SPARE_5] + sent_count[ACT_SPARE_6] + sent_count[ACT_SPARE_7]);
      $display("Longest list %0d; %0d bad-position, %0d pool-full, %0d not-found responses.",
               peak_length, status_count[STAT_BAD_POS], status_count[STAT_FULL],
               status_count[STAT_NOTFOUND]);
      if (failures == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/llpe_pkg.sv
hdl/llpe_ram.sv
hdl/linked_list_position_engine_unit.sv
bench/tb_linked_list_position_engine_unit.sv
